// ===== rtl/rps_pkg.sv =====
// Shared types and constants for the rock-paper-scissors cellular automaton.
// Holds the controller state type, the operation, kind and register codes,
// and the predator function. It depends on nothing else.
`default_nettype none

package rps_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int OP_W        = 2;
    localparam int COORD_W     = 6;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int THRESH_W    = 4;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ROCK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAPER    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCISSORS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EAT_THRESHOLD = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_GRID_WIDTH    = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RST_GRID_HEIGHT   = 7'd64;
    localparam logic [THRESH_W-1:0]   RST_EAT_THRESHOLD = 4'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_PRIME,
        S_PRIME_LOAD,
        S_FETCH,
        S_LOAD,
        S_CELL,
        S_WRITE
    } state_t;

    function automatic logic [KIND_W-1:0] hunter_of(input logic [KIND_W-1:0] kind);
        logic [KIND_W-1:0] result;
        case (kind)
            KIND_ROCK:     result = KIND_PAPER;
            KIND_PAPER:    result = KIND_SCISSORS;
            KIND_SCISSORS: result = KIND_ROCK;
            default:       result = kind;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rock_paper_scissors_automaton.sv =====
// Top level of the rock-paper-scissors cellular automaton: two row-wide grid banks,
// the read-modify-write path for single cells and the row-window generation sweep.
// It depends on rps_pkg.
// A read or write transfer gives its result after the access state and the done register;
// busy is high for one cycle, so a new transfer is taken only once the last has left that
// state. A step keeps busy high while the three-row window passes over every memory row
// at one cell a cycle. Reset clears both banks row by row with busy high. Results are
// one-cycle strobes; the receiver cannot stall them.
`default_nettype none

module rock_paper_scissors_automaton
    import rps_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [OP_W-1:0]        op,
    input  wire logic [COORD_W-1:0]     col,
    input  wire logic [COORD_W-1:0]     row,
    input  wire logic [KIND_W-1:0]      write_kind,
    output logic                        done,
    output logic [KIND_W-1:0]           read_kind,
    output logic                        out_of_range,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW      = $clog2(MAX_COLS);
    localparam int RW      = $clog2(MAX_ROWS);
    localparam int CDIM_W  = $clog2(MAX_COLS + 1);
    localparam int RDIM_W  = $clog2(MAX_ROWS + 1);
    localparam int DIM_A_W = (CDIM_W > RDIM_W) ? CDIM_W : RDIM_W;
    localparam int DIM_W   = (DIM_A_W > CFG_DATA_W) ? DIM_A_W : CFG_DATA_W;

    typedef logic [MAX_COLS-1:0][KIND_W-1:0] row_t;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] grid_width_reg;
    logic [CFG_DATA_W-1:0] grid_height_reg;
    logic [THRESH_W-1:0]   eat_threshold_reg;

    logic          active_reg, active_next;
    logic [CW-1:0] x_reg, x_next;
    logic [RW-1:0] y_reg, y_next;
    logic [RW-1:0] clr_reg, clr_next;
    logic          done_reg, done_next;
    logic [KIND_W-1:0] read_kind_reg, read_kind_next;
    logic          oor_reg, oor_next;

    logic [OP_W-1:0]   op_reg;
    logic [CW-1:0]     col_idx_reg;
    logic [RW-1:0]     row_idx_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              outside_reg;

    row_t bank0_mem [MAX_ROWS];
    row_t bank1_mem [MAX_ROWS];
    row_t rd0_reg, rd1_reg;
    row_t src_row, mod_row;
    row_t mid_row_reg, bot_row_reg;
    row_t sh_top_reg, sh_mid_reg, sh_bot_reg;
    row_t out_row_reg;
    logic [KIND_W-1:0] left_top_reg, left_mid_reg, left_bot_reg;

    logic [RW-1:0] rd_addr, wr_addr;
    row_t          wr_data;
    logic          we0, we1;
    logic          item_load;

    logic [DIM_W-1:0] cols_used, rows_used;
    logic [DIM_W-1:0] gw_ext, gh_ext;
    logic [RW-1:0]    in_row_idx;
    logic             outside_in;
    logic [RW-1:0]    fetch_row;

    logic              vl, vr, vt, vb, in_grid;
    logic [KIND_W-1:0] self_kind, hunter;
    logic [7:0]        hits;
    logic [3:0]        hunter_cnt;
    logic [KIND_W-1:0] new_cell;

    assign gw_ext    = DIM_W'(grid_width_reg);
    assign gh_ext    = DIM_W'(grid_height_reg);
    assign cols_used = (gw_ext == '0) ? DIM_W'(1) :
                       (gw_ext > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : gw_ext;
    assign rows_used = (gh_ext == '0) ? DIM_W'(1) :
                       (gh_ext > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : gh_ext;

    assign in_row_idx = RW'(row);
    assign outside_in = (DIM_W'(col) >= cols_used) || (DIM_W'(row) >= rows_used);
    assign fetch_row  = (y_reg == RW'(MAX_ROWS - 1)) ? '0 : y_reg + RW'(1);

    assign src_row = active_reg ? rd1_reg : rd0_reg;

    always_comb
    begin
        mod_row = src_row;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            if (CW'(i) == col_idx_reg)
            begin
                mod_row[i] = kind_reg;
            end
        end
    end

    assign vl        = (x_reg != '0);
    assign vr        = (DIM_W'(x_reg) + DIM_W'(1)) < cols_used;
    assign vt        = (y_reg != '0);
    assign vb        = (DIM_W'(y_reg) + DIM_W'(1)) < rows_used;
    assign in_grid   = (DIM_W'(x_reg) < cols_used) && (DIM_W'(y_reg) < rows_used);
    assign self_kind = sh_mid_reg[0];
    assign hunter    = hunter_of(self_kind);

    always_comb
    begin
        hits[0] = vl && vt && (left_top_reg == hunter);
        hits[1] = vl && (left_mid_reg == hunter);
        hits[2] = vl && vb && (left_bot_reg == hunter);
        hits[3] = vt && (sh_top_reg[0] == hunter);
        hits[4] = vb && (sh_bot_reg[0] == hunter);
        hits[5] = vr && vt && (sh_top_reg[1] == hunter);
        hits[6] = vr && (sh_mid_reg[1] == hunter);
        hits[7] = vr && vb && (sh_bot_reg[1] == hunter);
        hunter_cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            hunter_cnt = hunter_cnt + 4'(hits[i]);
        end
    end

    assign new_cell = (in_grid && (self_kind != KIND_INVALID) &&
                       (hunter_cnt > eat_threshold_reg)) ? hunter : self_kind;

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        clr_next       = clr_reg;
        done_next      = 1'b0;
        read_kind_next = KIND_ROCK;
        oor_next       = 1'b0;
        busy           = 1'b1;
        rd_addr        = y_reg;
        wr_addr        = y_reg;
        wr_data        = out_row_reg;
        we0            = 1'b0;
        we1            = 1'b0;
        item_load      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_addr  = clr_reg;
                wr_data  = '0;
                we0      = 1'b1;
                we1      = 1'b1;
                clr_next = clr_reg + RW'(1);
                if (clr_reg == RW'(MAX_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy    = 1'b0;
                rd_addr = in_row_idx;
                if (start)
                begin
                    item_load = 1'b1;
                    case (op)
                        OP_WRITE, OP_READ: state_next = S_ACCESS;
                        OP_STEP:           state_next = S_PRIME;
                        default:           state_next = S_IDLE;
                    endcase
                end
            end
            S_ACCESS:
            begin
                wr_addr   = row_idx_reg;
                wr_data   = mod_row;
                done_next = 1'b1;
                oor_next  = outside_reg;
                if ((op_reg == OP_WRITE) && !outside_reg && (kind_reg != KIND_INVALID))
                begin
                    we0 = !active_reg;
                    we1 = active_reg;
                end
                if ((op_reg == OP_READ) && !outside_reg)
                begin
                    read_kind_next = src_row[col_idx_reg];
                end
                state_next = S_IDLE;
            end
            S_PRIME:
            begin
                rd_addr    = '0;
                y_next     = '0;
                state_next = S_PRIME_LOAD;
            end
            S_PRIME_LOAD:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                rd_addr    = fetch_row;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                x_next     = '0;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                x_next = x_reg + CW'(1);
                if (x_reg == CW'(MAX_COLS - 1))
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                we0 = active_reg;
                we1 = !active_reg;
                if (y_reg == RW'(MAX_ROWS - 1))
                begin
                    active_next = !active_reg;
                    state_next  = S_IDLE;
                end
                else
                begin
                    y_next     = y_reg + RW'(1);
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            active_reg <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg    <= RST_GRID_WIDTH;
            grid_height_reg   <= RST_GRID_HEIGHT;
            eat_threshold_reg <= RST_EAT_THRESHOLD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:    grid_width_reg    <= cfg_data;
                REG_GRID_HEIGHT:   grid_height_reg   <= cfg_data;
                REG_EAT_THRESHOLD: eat_threshold_reg <= cfg_data[THRESH_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            bank0_mem[wr_addr] <= wr_data;
        end
        if (we1)
        begin
            bank1_mem[wr_addr] <= wr_data;
        end
        rd0_reg <= bank0_mem[rd_addr];
        rd1_reg <= bank1_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        read_kind_reg <= read_kind_next;
        oor_reg       <= oor_next;
        if (item_load)
        begin
            op_reg      <= op;
            col_idx_reg <= CW'(col);
            row_idx_reg <= in_row_idx;
            kind_reg    <= write_kind;
            outside_reg <= outside_in;
        end
        case (state_reg)
            S_PRIME_LOAD:
            begin
                bot_row_reg <= src_row;
            end
            S_LOAD:
            begin
                mid_row_reg <= bot_row_reg;
                bot_row_reg <= src_row;
                sh_top_reg  <= mid_row_reg;
                sh_mid_reg  <= bot_row_reg;
                sh_bot_reg  <= src_row;
            end
            S_CELL:
            begin
                left_top_reg <= sh_top_reg[0];
                left_mid_reg <= sh_mid_reg[0];
                left_bot_reg <= sh_bot_reg[0];
                sh_top_reg   <= {KIND_ROCK, sh_top_reg[MAX_COLS-1:1]};
                sh_mid_reg   <= {KIND_ROCK, sh_mid_reg[MAX_COLS-1:1]};
                sh_bot_reg   <= {KIND_ROCK, sh_bot_reg[MAX_COLS-1:1]};
                out_row_reg  <= {new_cell, out_row_reg[MAX_COLS-1:1]};
            end
            default:
            begin
            end
        endcase
    end

    assign done         = done_reg;
    assign read_kind    = read_kind_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

// ===== rtl/rps_checker.sv =====
// Port-level checker for the rock-paper-scissors cellular automaton, with its bind.
// It depends on rps_pkg and watches the top level's ports only.
`default_nettype none

module rps_checker
    import rps_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [OP_W-1:0]   op,
    input wire logic              done,
    input wire logic [KIND_W-1:0] read_kind,
    input wire logic              out_of_range
);

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_WRITE || op == OP_READ)) |-> ##2 done)
        else $error("A cell transfer did not produce its result two cycles later.");

    a_step_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_STEP) |=> busy)
        else $error("A generation step did not hold busy.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Two results arrived in consecutive cycles.");

    a_outside_reads_rock: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (read_kind == KIND_ROCK))
        else $error("An out-of-range result carried a nonzero kind.");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (read_kind != KIND_INVALID))
        else $error("A result carried an illegal cell kind.");

endmodule

bind rock_paper_scissors_automaton rps_checker u_rps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .done         (done),
    .read_kind    (read_kind),
    .out_of_range (out_of_range)
);

`default_nettype wire
